[sv/bcg_pkg.sv]
// Package for the beep cadence generator: request/response payload types,
// mode and cadence codes, cadence timing constants, register reset values.
// No dependencies.
package bcg_pkg;

   localparam int unsigned FreqWidth  = 15;
   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned DurWidth   = 16;
   localparam int unsigned SpanWidth  = 11;
   localparam int unsigned CsrIdxWidth = 2;

   typedef struct packed {
      logic [1:0]           mode;
      logic [TimeWidth-1:0] now_ms;
      logic [2:0]           cadence;
      logic [FreqWidth-1:0] beep_freq_hz;
      logic [DurWidth-1:0]  beep_duration_ms;
   } req_type;

   typedef struct packed {
      logic                 tone_on;
      logic [FreqWidth-1:0] tone_freq_hz;
   } rsp_type;

   // request modes
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_BEEP    = 2'd1;
   localparam logic [1:0] MODE_CADENCE = 2'd2;

   // cadence codes
   localparam logic [2:0] CAD_OFF     = 3'd0;
   localparam logic [2:0] CAD_SLOW    = 3'd1;
   localparam logic [2:0] CAD_MEDIUM  = 3'd2;
   localparam logic [2:0] CAD_FAST    = 3'd3;
   localparam logic [2:0] CAD_CONT    = 3'd4;
   localparam logic [2:0] CAD_ERROR   = 3'd5;
   localparam logic [2:0] CAD_SUCCESS = 3'd6;

   // csr indexes
   localparam logic [CsrIdxWidth-1:0] CSR_ALERT_FREQ   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ERROR_FREQ   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_CONFIRM_FREQ = 2'd2;

   localparam logic [FreqWidth-1:0] ALERT_FREQ_RST   = 15'd4200;
   localparam logic [FreqWidth-1:0] ERROR_FREQ_RST   = 15'd200;
   localparam logic [FreqWidth-1:0] CONFIRM_FREQ_RST = 15'd2000;

   localparam logic [SpanWidth-1:0] SLOW_PERIOD_MS    = 11'd1000;
   localparam logic [SpanWidth-1:0] MEDIUM_PERIOD_MS  = 11'd500;
   localparam logic [SpanWidth-1:0] FAST_PERIOD_MS    = 11'd250;
   localparam logic [SpanWidth-1:0] CONT_SPAN_MS      = 11'd100;
   localparam logic [SpanWidth-1:0] BEEP_PULSE_MS     = 11'd80;
   localparam logic [SpanWidth-1:0] ERROR_SPAN_MS     = 11'd1000;
   localparam logic [SpanWidth-1:0] SUCCESS_PERIOD_MS = 11'd400;
   localparam logic [SpanWidth-1:0] SUCCESS_PULSE_MS  = 11'd150;

endpackage

[sv/bcg_req_reg.sv]
// Request input register of the beep cadence generator.
// Holds one request until the core passes it on. Depends on bcg_pkg.
module bcg_req_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bcg_pkg::req_type req_data,
   input  logic             advance,
   output logic             held_valid,
   output bcg_pkg::req_type held_data
);
   import bcg_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    accept;

   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & ~advance);
   assign data_in   = accept ? req_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;
endmodule

[sv/bcg_core.sv]
// Cadence state, tone registers and the per-request update logic.
// State advances when a request moves to the response register. Depends on bcg_pkg.
module bcg_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [bcg_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [bcg_pkg::FreqWidth-1:0]        csr_wr_data,
   input  logic                                 advance,
   input  bcg_pkg::req_type                     item,
   output bcg_pkg::rsp_type                     result
);
   import bcg_pkg::*;

   logic [FreqWidth-1:0] alert_ff, alert_in;
   logic [FreqWidth-1:0] error_ff, error_in;
   logic [FreqWidth-1:0] confirm_ff, confirm_in;

   logic [2:0]           cadence_ff, cadence_in;
   logic                 high_ff, high_in;
   logic                 started_ff, started_in;
   logic [TimeWidth-1:0] toggle_ff, toggle_in;
   logic [SpanWidth-1:0] period_ff, period_in;
   logic [SpanWidth-1:0] pulse_ff, pulse_in;
   logic [FreqWidth-1:0] active_ff, active_in;
   logic [TimeWidth-1:0] beep_end_ff, beep_end_in;
   logic                 beep_ff, beep_in;
   logic [FreqWidth-1:0] driven_ff, driven_in;

   logic [TimeWidth-1:0] elapsed;
   logic [TimeWidth-1:0] beep_left;
   logic [2:0]           new_cad;

   assign elapsed   = item.now_ms - toggle_ff;
   assign beep_left = item.now_ms - beep_end_ff;
   assign new_cad   = (item.cadence > CAD_SUCCESS) ? CAD_OFF : item.cadence;

   always_comb begin
      alert_in   = alert_ff;
      error_in   = error_ff;
      confirm_in = confirm_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALERT_FREQ:   alert_in   = csr_wr_data;
            CSR_ERROR_FREQ:   error_in   = csr_wr_data;
            CSR_CONFIRM_FREQ: confirm_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cadence_in  = cadence_ff;
      high_in     = high_ff;
      started_in  = started_ff;
      toggle_in   = toggle_ff;
      period_in   = period_ff;
      pulse_in    = pulse_ff;
      active_in   = active_ff;
      beep_end_in = beep_end_ff;
      beep_in     = beep_ff;
      driven_in   = driven_ff;
      unique case (item.mode)
         MODE_TICK: begin
            priority if (beep_ff) begin
               if (!beep_left[TimeWidth-1]) begin
                  beep_in = 1'b0;
                  high_in = 1'b0;
               end
            end else if (cadence_ff == CAD_OFF) begin
               high_in = 1'b0;
            end else if (cadence_ff == CAD_CONT) begin
               if (!high_ff) begin
                  high_in   = 1'b1;
                  driven_in = active_ff;
               end
            end else if (!started_ff) begin
               started_in = 1'b1;
               toggle_in  = item.now_ms;
               high_in    = 1'b1;
               driven_in  = active_ff;
            end else if (high_ff) begin
               if (elapsed >= {{(TimeWidth-SpanWidth){1'b0}}, pulse_ff}) begin
                  high_in = 1'b0;
               end
            end else begin
               if (elapsed >= {{(TimeWidth-SpanWidth){1'b0}}, period_ff}) begin
                  toggle_in = item.now_ms;
                  high_in   = 1'b1;
                  driven_in = active_ff;
               end
            end
         end
         MODE_BEEP: begin
            beep_in     = 1'b1;
            beep_end_in = item.now_ms + {{(TimeWidth-DurWidth){1'b0}}, item.beep_duration_ms};
            high_in     = 1'b1;
            driven_in   = item.beep_freq_hz;
         end
         MODE_CADENCE: begin
            if (new_cad != cadence_ff) begin
               cadence_in = new_cad;
               started_in = 1'b0;
               beep_in    = 1'b0;
               active_in  = alert_ff;
               unique case (new_cad)
                  CAD_SLOW: begin
                     period_in = SLOW_PERIOD_MS;
                     pulse_in  = BEEP_PULSE_MS;
                  end
                  CAD_MEDIUM: begin
                     period_in = MEDIUM_PERIOD_MS;
                     pulse_in  = BEEP_PULSE_MS;
                  end
                  CAD_FAST: begin
                     period_in = FAST_PERIOD_MS;
                     pulse_in  = BEEP_PULSE_MS;
                  end
                  CAD_CONT: begin
                     period_in = CONT_SPAN_MS;
                     pulse_in  = CONT_SPAN_MS;
                  end
                  CAD_ERROR: begin
                     active_in = error_ff;
                     period_in = ERROR_SPAN_MS;
                     pulse_in  = ERROR_SPAN_MS;
                  end
                  CAD_SUCCESS: begin
                     active_in = confirm_ff;
                     period_in = SUCCESS_PERIOD_MS;
                     pulse_in  = SUCCESS_PULSE_MS;
                  end
                  default: begin
                     period_in = '0;
                     pulse_in  = '0;
                     high_in   = 1'b0;
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   assign result.tone_on      = high_in;
   assign result.tone_freq_hz = high_in ? driven_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         alert_ff   <= ALERT_FREQ_RST;
         error_ff   <= ERROR_FREQ_RST;
         confirm_ff <= CONFIRM_FREQ_RST;
      end else begin
         alert_ff   <= alert_in;
         error_ff   <= error_in;
         confirm_ff <= confirm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cadence_ff  <= CAD_OFF;
         high_ff     <= 1'b0;
         started_ff  <= 1'b0;
         toggle_ff   <= '0;
         period_ff   <= SLOW_PERIOD_MS;
         pulse_ff    <= BEEP_PULSE_MS;
         active_ff   <= ALERT_FREQ_RST;
         beep_end_ff <= '0;
         beep_ff     <= 1'b0;
         driven_ff   <= ALERT_FREQ_RST;
      end else if (advance) begin
         cadence_ff  <= cadence_in;
         high_ff     <= high_in;
         started_ff  <= started_in;
         toggle_ff   <= toggle_in;
         period_ff   <= period_in;
         pulse_ff    <= pulse_in;
         active_ff   <= active_in;
         beep_end_ff <= beep_end_in;
         beep_ff     <= beep_in;
         driven_ff   <= driven_in;
      end
   end
endmodule

[sv/bcg_rsp_reg.sv]
// Response output register of the beep cadence generator.
// Holds one response while the receiver stalls. Depends on bcg_pkg.
module bcg_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bcg_pkg::rsp_type load_data,
   output logic             ready,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bcg_pkg::rsp_type rsp_data
);
   import bcg_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign ready    = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

[sv/beep_cadence_generator_top.sv]
// Beep cadence generator top level: buzzer gate and tone frequency per request.
// Instantiates bcg_req_reg, bcg_core and bcg_rsp_reg. Depends on bcg_pkg.
//
// Usage:
//   req_ channel: one request per accepted edge (req_valid high, req_stall low):
//   a tick, a single-beep trigger or a cadence change.
//   rsp_ channel: exactly one response per request, in order: tone_on and the
//   selected tone frequency (zero while the tone is off).
//   csr_ port: tone frequencies for alert, error and confirm cadences,
//   written while no request is in flight.
//   Path: a request passes the input register into the response register,
//   where rsp_valid rises; a receiver stall can hold it in the input register.
//   Throughput: one request per cycle while the receiver does not stall; the
//   state update of one request is a single pass of compare/add logic, so the next one follows directly.
//   Receiver stall: the response register holds; one more request waits in
//   the input register, after which req_stall rises.
//   Reset: cadence off, tone off, frequencies at their defaults, both
//   registers empty. Requests are taken as soon as reset is released.
module beep_cadence_generator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bcg_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bcg_pkg::rsp_type                rsp_data,
   input  logic                            csr_wr_en,
   input  logic [bcg_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [bcg_pkg::FreqWidth-1:0]   csr_wr_data
);
   import bcg_pkg::*;

   logic    held_valid;
   req_type held_data;
   logic    rsp_ready;
   logic    advance;
   rsp_type result;

   assign advance = held_valid & rsp_ready;

   bcg_req_reg u_req_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   bcg_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .item        (held_data),
      .result      (result)
   );

   bcg_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (result),
      .ready     (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

[sv/bcg_checker.sv]
// Port-level checks for beep_cadence_generator_top, bound to the top level.
// Depends on bcg_pkg.
module bcg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input bcg_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bcg_pkg::rsp_type rsp_data
);
   import bcg_pkg::*;

   // stalled request held by the sender
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed under stall");

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed under stall");

   // silent gate reports zero frequency
   a_tone_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tone_on |-> rsp_data.tone_freq_hz == '0)
      else $error("nonzero frequency with tone off");

   // input only backs up behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");
endmodule

bind beep_cadence_generator_top bcg_checker u_bcg_checker (.*);
